FILE: rtl/core/fourier_axial_field_expansion_defines.svh
// Assertion macros for the Fourier axial field expansion block.
// No dependencies; included by the checker.
`ifndef FOURIER_AXIAL_FIELD_EXPANSION_DEFINES_SVH
`define FOURIER_AXIAL_FIELD_EXPANSION_DEFINES_SVH

// same-cycle implication, disabled in reset
`define FAXE_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define FAXE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/faxe_pkg.sv
// Shared types, constants and helpers of the Fourier axial field expansion.
// No dependencies.
`timescale 1ns / 1ps

package faxe_pkg;

  localparam int MAX_HARMONICS_DEF = 64;
  localparam int FIELD_WIDTH_DEF   = 48;

  localparam int COEF_W = 48;   // table entries, inputs and outputs of the field
  localparam int POS_W  = 32;   // Q7.24 positions
  localparam int CFG_W  = 32;   // widest config register
  localparam int CFG_IDX_W = 2;
  localparam int NH_W   = 7;
  localparam int SAT_W  = 66;   // holds the sum of two 65-bit values
  localparam int MUL_W  = 64;   // shared multiplier operand width
  localparam int SH_W   = 7;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_EVAL = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_Z_BEGIN   = 2'd0,
    REG_PHASE_PM  = 2'd1,
    REG_NUM_HARM  = 2'd2
  } cfg_reg_t;

  localparam logic [CFG_W-1:0] PPM_RESET = 32'd65536;
  localparam logic [NH_W-1:0]  NH_RESET  = 7'd1;

  // 2^32 / (2*pi) scaled so that bits 40..71 of k*dz give a Q32 turn
  localparam logic [29:0] INV2PI_Q32  = 30'd683565276;
  localparam logic [31:0] PI_Q30      = 32'd3373259426;
  localparam logic [32:0] CORDIC_GAIN = 33'h026DD3B6A;
  localparam int          CORDIC_STEPS = 30;
  localparam int          CI_W = 5;

  localparam logic [30:0] ATAN_TAB [CORDIC_STEPS] = '{
    31'h3243F6A8, 31'h1DAC6705, 31'h0FADBAFC, 31'h07F56EA6, 31'h03FEAB76,
    31'h01FFD55B, 31'h00FFFAAA, 31'h007FFF55, 31'h003FFFEA, 31'h001FFFFD,
    31'h000FFFFF, 31'h0007FFFF, 31'h0003FFFF, 31'h0001FFFF, 31'h0000FFFF,
    31'h00007FFF, 31'h00003FFF, 31'h00001FFF, 31'h00000FFF, 31'h000007FF,
    31'h000003FF, 31'h000001FF, 31'h000000FF, 31'h0000007F, 31'h0000003F,
    31'h0000001F, 31'h0000000F, 31'h00000008, 31'h00000004, 31'h00000002
  };

  typedef struct packed {
    logic                    start;
    logic signed [MUL_W-1:0] val;
    logic [MUL_W-1:0]        mag;
    logic                    neg;
    logic [SH_W-1:0]         sh;
  } mul_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [MUL_W-1:0] res;
  } mul_rsp_t;

  // symmetric saturating add
  function automatic logic signed [SAT_W-1:0] sat_add(input logic signed [SAT_W-1:0] a,
                                                      input logic signed [SAT_W-1:0] b,
                                                      input logic signed [SAT_W-1:0] m);
    logic signed [SAT_W-1:0] s;
    s = a + b;
    if (s > m) return m;
    if (s < -m) return -m;
    return s;
  endfunction

  function automatic logic [MUL_W-1:0] abs_mag(input logic signed [SAT_W-1:0] v);
    logic signed [SAT_W-1:0] n;
    n = -v;
    return v[SAT_W-1] ? n[MUL_W-1:0] : v[MUL_W-1:0];
  endfunction

endpackage

FILE: rtl/core/fourier_axial_field_expansion.sv
// Paraxial E field from a Fourier table of the on-axis field; load or evaluate.
// Evaluate sums the constant term and harmonics 1 to H-1, H = clamped
// num_harmonics; one item at a time, in_ready high only when idle.
// Per harmonic: 2 table reads, 30 CORDIC steps, 9 passes of the shared
// multiplier. Sync active-low reset clears control and config; the
// coefficient table is not cleared (the user must write it before it is read; the block does not enforce this).
`timescale 1ns / 1ps

module fourier_axial_field_expansion import faxe_pkg::*; #(
  parameter int MAX_HARMONICS = MAX_HARMONICS_DEF,
  parameter int FIELD_WIDTH   = FIELD_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // config write port
  input  logic                                   cfg_we,
  input  logic [CFG_IDX_W-1:0]                   cfg_index,
  input  logic [CFG_W-1:0]                       cfg_data,
  // input beat
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   in_func,
  input  logic [$clog2(2*MAX_HARMONICS-1)-1:0]   in_coef_index,
  input  logic signed [COEF_W-1:0]               in_coef_value,
  input  logic signed [POS_W-1:0]                in_pos_x,
  input  logic signed [POS_W-1:0]                in_pos_y,
  input  logic signed [POS_W-1:0]                in_pos_z,
  input  logic signed [COEF_W-1:0]               in_e_in_x,
  input  logic signed [COEF_W-1:0]               in_e_in_y,
  input  logic signed [COEF_W-1:0]               in_e_in_z,
  // result beat
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [COEF_W-1:0]               out_e_out_x,
  output logic signed [COEF_W-1:0]               out_e_out_y,
  output logic signed [COEF_W-1:0]               out_e_out_z
);

  localparam int DEPTH = 2 * MAX_HARMONICS - 1;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int HC_W  = $clog2(MAX_HARMONICS + 1);
  localparam int W_W   = CFG_W + HC_W;      // w = k*l
  localparam int TK_W  = CFG_W + 30;        // k * 1/(2 pi)
  localparam int CW    = 33;                // CORDIC datapath
  localparam logic signed [SAT_W-1:0] FMAX =
    (SAT_W'(1) << (FIELD_WIDTH - 1)) - SAT_W'(1);
  localparam logic signed [SAT_W-1:0] OUT_MAX =
    (SAT_W'(1) << (COEF_W - 1)) - SAT_W'(1);
  localparam logic [SH_W-1:0] SH_TRIG = 7'd30;
  localparam logic [SH_W-1:0] SH_W16  = 7'd16;
  localparam logic [SH_W-1:0] SH_R3   = 7'd52;
  localparam logic [SH_W-1:0] SH_R2   = 7'd50;
  localparam logic [SH_W-1:0] SH_POS  = 7'd24;

  typedef enum logic [12:0] {
    S_IDLE = 13'b0000000000001,
    S_TK   = 13'b0000000000010,  // k/(2 pi), read constant term
    S_PLO  = 13'b0000000000100,  // low partial product of phase
    S_PHI  = 13'b0000000001000,  // high partial product of phase
    S_PH   = 13'b0000000010000,  // phase sum
    S_RDA  = 13'b0000000100000,  // read cosine part, set up CORDIC
    S_RDB  = 13'b0000001000000,  // read sine part
    S_CRD  = 13'b0000010000000,  // CORDIC steps
    S_MST  = 13'b0000100000000,  // start multiplier
    S_MWT  = 13'b0001000000000,  // wait for multiplier
    S_R2A  = 13'b0010000000000,  // x^2
    S_R2B  = 13'b0100000000000,  // r^2
    S_OUT  = 13'b1000000000000   // add to incoming field
  } state_t;

  // multiplier passes, in issue order
  typedef enum logic [3:0] {
    OP_AC, OP_BS, OP_AS, OP_BC,       // a,b times cos,sin
    OP_T1W, OP_T0W, OP_VW2, OP_U1W, OP_XW2,  // derivative scaling by w
    OP_R3, OP_FX, OP_FY, OP_R2        // off-axis expansion
  } mop_t;

  state_t state_r;
  mop_t   mop_r;

  // config
  logic signed [POS_W-1:0] z_begin_r;
  logic [CFG_W-1:0]        ppm_r;
  logic [NH_W-1:0]         nharm_r;

  // captured item
  logic signed [POS_W-1:0]  x_r, y_r;
  logic signed [POS_W:0]    d_r;
  logic signed [COEF_W-1:0] ein_x_r, ein_y_r, ein_z_r;
  logic [HC_W-1:0]          nh_r, l_r;

  // phase
  logic [TK_W-1:0]         tk_r;
  logic signed [64:0]      plo_r, phi_r;
  logic [31:0]             ph_r, phl_r;
  logic [W_W-1:0]          w_r;

  // CORDIC
  logic signed [CW-1:0]    cx_r, cy_r, cz_r;
  logic signed [CW-1:0]    cx_nxt, cy_nxt, cz_nxt;
  logic [1:0]              q_r;
  logic [CI_W-1:0]         ci_r;

  logic signed [COEF_W-1:0] a_r, b_r;
  logic signed [FIELD_WIDTH-1:0] p0_r, p1_r, p2_r, t0_r, t1_r, u1_r, v_r;
  logic signed [FIELD_WIDTH-1:0] ez_r, ezp_r, ezpp_r, ezppp_r, er_r, f0_r, f1_r, f2_r;
  logic [63:0]             sq_r, rr2_r;

  logic signed [COEF_W-1:0] out_x_r, out_y_r, out_z_r;
  logic                     out_valid_r;

  // table port
  logic              ram_we, ram_re;
  logic [IDX_W-1:0]  ram_raddr;
  logic [COEF_W-1:0] ram_rdata;

  mul_req_t mreq;
  mul_rsp_t mrsp;

  logic in_acc, out_free;
  logic [HC_W-1:0] nh_nxt;
  logic [IDX_W-1:0] addr_a;
  logic [31:0] u_ph;
  logic signed [30:0] r_ph, r_neg;
  logic [29:0] r_mag;
  logic [61:0] z_prod;
  logic signed [CW-1:0] z_init, z_mag;
  logic signed [CW-1:0] cos_v, sin_v, xs, ys, at;
  logic [31:0] xm, ym;
  logic signed [95:0] psum;
  logic signed [FIELD_WIDTH-1:0] ezp_half;

  function automatic logic signed [FIELD_WIDTH-1:0] sadd(
      input logic signed [SAT_W-1:0] a, input logic signed [SAT_W-1:0] b);
    return FIELD_WIDTH'(sat_add(a, b, FMAX));
  endfunction

  function automatic logic signed [COEF_W-1:0] oadd(
      input logic signed [SAT_W-1:0] a, input logic signed [SAT_W-1:0] b);
    return COEF_W'(sat_add(a, b, OUT_MAX));
  endfunction

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // a load beyond the table is dropped
  assign ram_we = in_acc && (in_func == FUNC_LOAD) && (in_coef_index < IDX_W'(DEPTH));

  assign addr_a = IDX_W'({l_r, 1'b0}) - IDX_W'(1);

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = '0;
    case (state_r)
      S_TK:  ram_re = 1'b1;
      S_RDA: begin
        ram_re    = 1'b1;
        ram_raddr = addr_a;
      end
      S_RDB: begin
        ram_re    = 1'b1;
        ram_raddr = IDX_W'({l_r, 1'b0});
      end
      default: ;
    endcase
  end

  faxe_ram #(
    .WIDTH (COEF_W),
    .DEPTH (DEPTH)
  ) u_coef_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_coef_index),
    .wdata (in_coef_value),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // zero acts as one, above the table size clamps
  always_comb begin
    if (nharm_r == '0) nh_nxt = HC_W'(1);
    else if (32'(nharm_r) > 32'(MAX_HARMONICS)) nh_nxt = HC_W'(MAX_HARMONICS);
    else nh_nxt = HC_W'(nharm_r);
  end

  // CORDIC set-up: quadrant from the top bits, residual in [-pi/4, pi/4)
  assign u_ph   = phl_r + 32'h2000_0000;
  assign r_ph   = $signed({1'b0, u_ph[29:0]}) - 31'sh2000_0000;
  assign r_neg  = -r_ph;
  assign r_mag  = r_ph[30] ? r_neg[29:0] : r_ph[29:0];
  assign z_prod = r_mag * PI_Q30;
  assign z_mag  = $signed({2'b00, z_prod[61:31]});
  assign z_init = r_ph[30] ? -z_mag : z_mag;

  assign xs = cx_r >>> ci_r;
  assign ys = cy_r >>> ci_r;
  assign at = $signed({2'b00, ATAN_TAB[ci_r]});

  always_comb begin
    if (!cz_r[CW-1]) begin
      cx_nxt = cx_r - ys;
      cy_nxt = cy_r + xs;
      cz_nxt = cz_r - at;
    end else begin
      cx_nxt = cx_r + ys;
      cy_nxt = cy_r - xs;
      cz_nxt = cz_r + at;
    end
  end

  always_comb begin
    case (q_r)
      2'd0: begin cos_v = cx_r;  sin_v = cy_r;  end
      2'd1: begin cos_v = -cy_r; sin_v = cx_r;  end
      2'd2: begin cos_v = -cx_r; sin_v = -cy_r; end
      default: begin cos_v = cy_r; sin_v = -cx_r; end
    endcase
  end

  assign xm = x_r[POS_W-1] ? (32'd0 - $unsigned(x_r)) : $unsigned(x_r);
  assign ym = y_r[POS_W-1] ? (32'd0 - $unsigned(y_r)) : $unsigned(y_r);

  // Q32 turn = bits 40..71 of the signed product tk * dz
  assign psum = (96'(phi_r) <<< 31) + 96'(plo_r);

  // ez'/2 truncated toward zero
  assign ezp_half = $signed(ezp_r + FIELD_WIDTH'(ezp_r[FIELD_WIDTH-1])) >>> 1;

  // operand select for the shared multiplier
  always_comb begin
    mreq       = '0;
    mreq.start = (state_r == S_MST);
    case (mop_r)
      OP_AC: begin
        mreq.val = MUL_W'(a_r);
        mreq.mag = abs_mag(SAT_W'(cos_v));
        mreq.neg = cos_v[CW-1];
        mreq.sh  = SH_TRIG;
      end
      OP_BS: begin
        mreq.val = MUL_W'(b_r);
        mreq.mag = abs_mag(SAT_W'(sin_v));
        mreq.neg = sin_v[CW-1];
        mreq.sh  = SH_TRIG;
      end
      OP_AS: begin
        mreq.val = MUL_W'(a_r);
        mreq.mag = abs_mag(SAT_W'(sin_v));
        mreq.neg = sin_v[CW-1];
        mreq.sh  = SH_TRIG;
      end
      OP_BC: begin
        mreq.val = MUL_W'(b_r);
        mreq.mag = abs_mag(SAT_W'(cos_v));
        mreq.neg = cos_v[CW-1];
        mreq.sh  = SH_TRIG;
      end
      OP_T1W: begin
        mreq.val = MUL_W'(t1_r);
        mreq.mag = MUL_W'(w_r);
        mreq.sh  = SH_W16;
      end
      OP_T0W: begin
        mreq.val = MUL_W'(t0_r);
        mreq.mag = MUL_W'(w_r);
        mreq.sh  = SH_W16;
      end
      OP_VW2, OP_XW2: begin
        mreq.val = MUL_W'(v_r);
        mreq.mag = MUL_W'(w_r);
        mreq.sh  = SH_W16;
      end
      OP_U1W: begin
        mreq.val = MUL_W'(u1_r);
        mreq.mag = MUL_W'(w_r);
        mreq.sh  = SH_W16;
      end
      OP_R3: begin
        mreq.val = MUL_W'(ezppp_r);
        mreq.mag = rr2_r;
        mreq.sh  = SH_R3;
      end
      OP_FX: begin
        mreq.val = MUL_W'(er_r);
        mreq.mag = MUL_W'(xm);
        mreq.neg = x_r[POS_W-1];
        mreq.sh  = SH_POS;
      end
      OP_FY: begin
        mreq.val = MUL_W'(er_r);
        mreq.mag = MUL_W'(ym);
        mreq.neg = y_r[POS_W-1];
        mreq.sh  = SH_POS;
      end
      OP_R2: begin
        mreq.val = MUL_W'(ezpp_r);
        mreq.mag = rr2_r;
        mreq.sh  = SH_R2;
      end
      default: ;
    endcase
  end

  faxe_mulsat #(
    .FIELD_WIDTH (FIELD_WIDTH)
  ) u_mulsat (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mreq),
    .rsp   (mrsp)
  );

  // config registers; the user must write them only between items (the block does not enforce this)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      z_begin_r <= '0;
      ppm_r     <= PPM_RESET;
      nharm_r   <= NH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_Z_BEGIN:  z_begin_r <= $signed(cfg_data);
        REG_PHASE_PM: ppm_r     <= cfg_data;
        REG_NUM_HARM: nharm_r   <= cfg_data[NH_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mop_r       <= OP_AC;
      out_valid_r <= 1'b0;
    end else begin
      // S_OUT owns out_valid_r in its own cycle
      if (out_valid_r && out_ready && (state_r != S_OUT)) out_valid_r <= 1'b0;

      case (state_r)
        S_IDLE: begin
          if (in_acc && (in_func == FUNC_EVAL)) begin
            x_r     <= in_pos_x;
            y_r     <= in_pos_y;
            d_r     <= (POS_W+1)'(in_pos_z) - (POS_W+1)'(z_begin_r);
            ein_x_r <= in_e_in_x;
            ein_y_r <= in_e_in_y;
            ein_z_r <= in_e_in_z;
            nh_r    <= nh_nxt;
            state_r <= S_TK;
          end
        end
        S_TK: begin
          tk_r    <= ppm_r * INV2PI_Q32;
          state_r <= S_PLO;
        end
        S_PLO: begin
          plo_r   <= $signed({1'b0, tk_r[30:0]}) * d_r;
          ez_r    <= sadd(SAT_W'($signed(ram_rdata)), '0);
          state_r <= S_PHI;
        end
        S_PHI: begin
          phi_r   <= $signed({1'b0, tk_r[TK_W-1:31]}) * d_r;
          state_r <= S_PH;
        end
        S_PH: begin
          ph_r    <= psum[71:40] + 32'h8000_0000;
          phl_r   <= psum[71:40] + 32'h8000_0000;
          w_r     <= W_W'(ppm_r);
          l_r     <= HC_W'(1);
          ezp_r   <= '0;
          ezpp_r  <= '0;
          ezppp_r <= '0;
          state_r <= (nh_r == HC_W'(1)) ? S_R2A : S_RDA;
        end
        S_RDA: begin
          q_r     <= u_ph[31:30];
          cx_r    <= $signed(CORDIC_GAIN);
          cy_r    <= '0;
          cz_r    <= z_init;
          ci_r    <= '0;
          state_r <= S_RDB;
        end
        S_RDB: begin
          a_r     <= $signed(ram_rdata);
          state_r <= S_CRD;
        end
        S_CRD: begin
          if (ci_r == '0) b_r <= $signed(ram_rdata);
          cx_r <= cx_nxt;
          cy_r <= cy_nxt;
          cz_r <= cz_nxt;
          ci_r <= ci_r + CI_W'(1);
          if (ci_r == CI_W'(CORDIC_STEPS - 1)) begin
            mop_r   <= OP_AC;
            state_r <= S_MST;
          end
        end
        S_MST: state_r <= S_MWT;
        S_MWT: begin
          if (mrsp.done) begin
            state_r <= S_MST;
            case (mop_r)
              OP_AC: begin
                p0_r  <= FIELD_WIDTH'(mrsp.res);
                mop_r <= OP_BS;
              end
              OP_BS: begin
                p1_r  <= FIELD_WIDTH'(mrsp.res);
                mop_r <= OP_AS;
              end
              OP_AS: begin
                p2_r  <= FIELD_WIDTH'(mrsp.res);
                mop_r <= OP_BC;
              end
              OP_BC: begin
                t0_r  <= sadd(SAT_W'(p0_r), -SAT_W'(p1_r));
                t1_r  <= sadd(-SAT_W'(p2_r), -SAT_W'(mrsp.res));
                mop_r <= OP_T1W;
              end
              OP_T1W: begin
                u1_r  <= FIELD_WIDTH'(mrsp.res);
                ezp_r <= sadd(SAT_W'(ezp_r), SAT_W'(mrsp.res));
                ez_r  <= sadd(SAT_W'(ez_r), SAT_W'(t0_r));
                mop_r <= OP_T0W;
              end
              OP_T0W: begin
                v_r   <= FIELD_WIDTH'(mrsp.res);
                mop_r <= OP_VW2;
              end
              OP_VW2: begin
                ezpp_r <= sadd(SAT_W'(ezpp_r), -SAT_W'(mrsp.res));
                mop_r  <= OP_U1W;
              end
              OP_U1W: begin
                v_r   <= FIELD_WIDTH'(mrsp.res);
                mop_r <= OP_XW2;
              end
              OP_XW2: begin
                ezppp_r <= sadd(SAT_W'(ezppp_r), -SAT_W'(mrsp.res));
                // next harmonic
                l_r     <= l_r + HC_W'(1);
                phl_r   <= phl_r + ph_r;
                w_r     <= w_r + W_W'(ppm_r);
                if (({1'b0, l_r} + (HC_W+1)'(1)) < {1'b0, nh_r}) state_r <= S_RDA;
                else state_r <= S_R2A;
              end
              OP_R3: begin
                er_r  <= sadd(-SAT_W'(ezp_half), SAT_W'(mrsp.res));
                mop_r <= OP_FX;
              end
              OP_FX: begin
                f0_r  <= FIELD_WIDTH'(mrsp.res);
                mop_r <= OP_FY;
              end
              OP_FY: begin
                f1_r  <= FIELD_WIDTH'(mrsp.res);
                mop_r <= OP_R2;
              end
              OP_R2: begin
                f2_r    <= sadd(SAT_W'(ez_r), -SAT_W'(mrsp.res));
                state_r <= S_OUT;
              end
              default: state_r <= S_IDLE;
            endcase
          end
        end
        S_R2A: begin
          sq_r    <= xm * xm;
          state_r <= S_R2B;
        end
        S_R2B: begin
          rr2_r   <= sq_r + ym * ym;
          mop_r   <= OP_R3;
          state_r <= S_MST;
        end
        S_OUT: begin
          // holds until the output register is free
          if (out_free) begin
            out_x_r     <= oadd(SAT_W'(ein_x_r), SAT_W'(f0_r));
            out_y_r     <= oadd(SAT_W'(ein_y_r), SAT_W'(f1_r));
            out_z_r     <= oadd(SAT_W'(ein_z_r), SAT_W'(f2_r));
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid   = out_valid_r;
  assign out_e_out_x = out_x_r;
  assign out_e_out_y = out_y_r;
  assign out_e_out_z = out_z_r;

endmodule

FILE: rtl/core/faxe_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module faxe_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 127
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/faxe_mulsat.sv
// Multi-cycle sign/magnitude multiplier: 64x16 partial products, shift,
// truncate toward zero, symmetric saturation. Uses faxe_pkg.
`timescale 1ns / 1ps

module faxe_mulsat import faxe_pkg::*; #(
  parameter int FIELD_WIDTH = FIELD_WIDTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  mul_req_t req,
  output mul_rsp_t rsp
);

  localparam int CHUNK  = 16;
  localparam int NCH    = MUL_W / CHUNK;
  localparam int CNT_W  = $clog2(NCH + 1);
  localparam int PROD_W = 2 * MUL_W;
  localparam logic [MUL_W-1:0] FMAX = (MUL_W'(1) << (FIELD_WIDTH - 1)) - MUL_W'(1);

  logic [MUL_W-1:0]       am_r, bm_r;
  logic [PROD_W-1:0]      acc_r;
  logic                   neg_r;
  logic [SH_W-1:0]        sh_r;
  logic [CNT_W-1:0]       cnt_r;
  logic                   busy_r, done_r;
  logic signed [MUL_W-1:0] res_r;

  logic [MUL_W+CHUNK-1:0] pp;
  logic [PROD_W-1:0]      shifted;
  logic [MUL_W-1:0]       mag, am_in, vneg;

  assign vneg    = MUL_W'(0) - $unsigned(req.val);
  assign am_in   = req.val[MUL_W-1] ? vneg : $unsigned(req.val);
  assign pp      = am_r * bm_r[MUL_W-1 -: CHUNK];
  assign shifted = acc_r >> sh_r;
  assign mag     = (shifted > PROD_W'(FMAX)) ? FMAX : shifted[MUL_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        am_r   <= am_in;
        bm_r   <= req.mag;
        neg_r  <= req.val[MUL_W-1] ^ req.neg;
        sh_r   <= req.sh;
        acc_r  <= '0;
        cnt_r  <= CNT_W'(NCH);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (cnt_r != '0) begin
          // most significant chunk first
          acc_r <= (acc_r << CHUNK) + PROD_W'(pp);
          bm_r  <= bm_r << CHUNK;
          cnt_r <= cnt_r - CNT_W'(1);
        end else begin
          res_r  <= neg_r ? $signed(MUL_W'(0) - mag) : $signed(mag);
          done_r <= 1'b1;
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.res  = res_r;

endmodule

FILE: rtl/core/faxe_chk.sv
// Port-level checker for the Fourier axial field expansion, with its bind.
// Uses fourier_axial_field_expansion_defines.svh.
`timescale 1ns / 1ps
`include "fourier_axial_field_expansion_defines.svh"

module faxe_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_func,
  input logic        out_valid,
  input logic        out_ready,
  input logic [47:0] out_e_out_x,
  input logic [47:0] out_e_out_z
);

  // stalled result beat holds valid and its x and z fields
  `FAXE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_e_out_x) && $stable(out_e_out_z), "result beat changed while stalled")

  // an evaluate beat keeps the block busy next cycle
  `FAXE_ASSERT_NEXT(a_eval_busy, clk, rst_n, in_valid && in_ready && in_func, !in_ready, "input taken while evaluating")

  // a load beat never yields a result
  `FAXE_ASSERT_NEXT(a_load_quiet, clk, rst_n, in_valid && in_ready && !in_func && !out_valid, !out_valid, "result after a load beat")

  // a result only appears at the end of an evaluation
  `FAXE_ASSERT_SAME(a_out_from_busy, clk, rst_n, $rose(out_valid), $past(!in_ready), "result appeared while idle")

endmodule

bind fourier_axial_field_expansion faxe_chk u_faxe_chk (.*);
